@@ rtl/tppp_pkg.sv @@
// shared types, codes and reset values for the thermal and power profile policy
package tppp_pkg;

	// default width of the millisecond timestamp
	localparam int TIME_BITS_DEF = 40;

	// configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EMERG_HR    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENTER_HR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXIT_HR     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EMERG_LVL   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_LVL   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd6;

	// configuration reset values
	localparam logic [15:0] RST_EMERG_HR  = 16'd4915;
	localparam logic [15:0] RST_ENTER_HR  = 16'd3686;
	localparam logic [15:0] RST_EXIT_HR   = 16'd2867;
	localparam logic [2:0]  RST_EMERG_LVL = 3'd5;
	localparam logic [2:0]  RST_PRESS_LVL = 3'd3;
	localparam logic [31:0] RST_HOLD_TIME = 32'd10000;
	localparam logic [31:0] RST_DEBOUNCE  = 32'd3000;

	// profiles, ordered by aggressiveness
	localparam logic [2:0] PROF_SAVE   = 3'd0;
	localparam logic [2:0] PROF_COMMON = 3'd1;
	localparam logic [2:0] PROF_BAL    = 3'd2;
	localparam logic [2:0] PROF_LITE   = 3'd3;
	localparam logic [2:0] PROF_PERF   = 3'd4;

	// transition reasons
	localparam logic [4:0] RSN_NONE       = 5'd0;
	localparam logic [4:0] RSN_STARTUP    = 5'd1;
	localparam logic [4:0] RSN_GAME_START = 5'd2;
	localparam logic [4:0] RSN_GAME_END   = 5'd3;
	localparam logic [4:0] RSN_PRESSURE   = 5'd4;
	localparam logic [4:0] RSN_EMERG      = 5'd5;
	localparam logic [4:0] RSN_RECOVER    = 5'd6;
	localparam logic [4:0] RSN_SAVER_ON   = 5'd7;
	localparam logic [4:0] RSN_SAVER_OFF  = 5'd8;
	localparam logic [4:0] RSN_SCREEN_OFF = 5'd9;
	localparam logic [4:0] RSN_SCREEN_ON  = 5'd10;
	localparam logic [4:0] RSN_STALE      = 5'd11;
	localparam logic [4:0] RSN_OFFLINE    = 5'd12;
	localparam logic [4:0] RSN_RESTORED   = 5'd13;
	localparam logic [4:0] RSN_CHARGING   = 5'd14;
	localparam logic [4:0] RSN_SHUTDOWN   = 5'd17;

	// telemetry health codes
	localparam logic [1:0] HEALTH_OK    = 2'd0;
	localparam logic [1:0] HEALTH_STALE = 2'd1;

	// width of the fixed input fields below the timestamp
	localparam int IN_FIXED_W = 36;
	// width of one packed result item
	localparam int RES_W = 15;

	// configuration register file contents
	typedef struct packed {
		logic [15:0] emerg_hr;
		logic [15:0] enter_hr;
		logic [15:0] exit_hr;
		logic [2:0]  emerg_lvl;
		logic [2:0]  press_lvl;
		logic [31:0] hold_time;
		logic [31:0] debounce;
	} cfg_t;

	// one result item, last field in the lowest bits
	typedef struct packed {
		logic [4:0] recorded_reason;
		logic       changed;
		logic       safety_flag;
		logic [4:0] reason_code;
		logic [2:0] profile;
	} res_t;

endpackage

@@ rtl/tppp_cfg.sv @@
// configuration register file for the profile policy
module tppp_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [tppp_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  logic [tppp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output tppp_pkg::cfg_t                   cfg
);

	tppp_pkg::cfg_t cfg_q;

	// register writes, indexes beyond the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.emerg_hr  <= tppp_pkg::RST_EMERG_HR;
			cfg_q.enter_hr  <= tppp_pkg::RST_ENTER_HR;
			cfg_q.exit_hr   <= tppp_pkg::RST_EXIT_HR;
			cfg_q.emerg_lvl <= tppp_pkg::RST_EMERG_LVL;
			cfg_q.press_lvl <= tppp_pkg::RST_PRESS_LVL;
			cfg_q.hold_time <= tppp_pkg::RST_HOLD_TIME;
			cfg_q.debounce  <= tppp_pkg::RST_DEBOUNCE;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				tppp_pkg::REG_EMERG_HR:  cfg_q.emerg_hr  <= cfg_wdata[15:0];
				tppp_pkg::REG_ENTER_HR:  cfg_q.enter_hr  <= cfg_wdata[15:0];
				tppp_pkg::REG_EXIT_HR:   cfg_q.exit_hr   <= cfg_wdata[15:0];
				tppp_pkg::REG_EMERG_LVL: cfg_q.emerg_lvl <= cfg_wdata[2:0];
				tppp_pkg::REG_PRESS_LVL: cfg_q.press_lvl <= cfg_wdata[2:0];
				tppp_pkg::REG_HOLD_TIME: cfg_q.hold_time <= cfg_wdata[31:0];
				tppp_pkg::REG_DEBOUNCE:  cfg_q.debounce  <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/tppp_core.sv @@
// policy state and combinational decision logic
module tppp_core #(
	parameter int TIME_BITS = tppp_pkg::TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  tppp_pkg::cfg_t        cfg,
	input  logic [1:0]            health,
	input  logic                  shutdown_req,
	input  logic [9:0]            sensor_flags,
	input  logic                  in_game,
	input  logic                  package_known,
	input  logic                  force_lite,
	input  logic [15:0]           headroom,
	input  logic signed [3:0]     thermal_level,
	input  logic [TIME_BITS-1:0]  now_time,
	output tppp_pkg::res_t        res
);

	// thermal judgement classes
	localparam logic [2:0] TH_UNKNOWN  = 3'd0;
	localparam logic [2:0] TH_BAND     = 3'd1;
	localparam logic [2:0] TH_PRESSURE = 3'd2;
	localparam logic [2:0] TH_EMERG    = 3'd3;
	localparam logic [2:0] TH_RECOVER  = 3'd4;

	// state registers
	logic [2:0]           cur_prof_q;
	logic [4:0]           last_reason_q;
	logic                 had_tel_q;
	logic                 prev_saver_q;
	logic                 prev_awake_q;
	logic                 prev_charging_q;
	logic [TIME_BITS-1:0] last_switch_q;

	// next state
	logic [2:0]           cur_prof_d;
	logic [4:0]           last_reason_d;
	logic                 had_tel_d;
	logic                 prev_saver_d;
	logic                 prev_awake_d;
	logic                 prev_charging_d;
	logic [TIME_BITS-1:0] last_switch_d;

	logic                 game;
	logic                 pw_av, saver, sc_av, awake, ch_av, chg, au_av, au_on;
	logic                 lvl_known, lvl_emerg, lvl_press;
	logic [2:0]           th;
	logic [TIME_BITS:0]   diff;
	logic [TIME_BITS-1:0] elapsed;
	logic                 hold_done, debounce_short;
	logic                 restored, saver_cleared, wake_edge, perf_now;
	logic [2:0]           prof;
	logic [4:0]           reason;
	logic                 safety;

	// field decode
	assign game  = in_game & package_known;
	assign pw_av = sensor_flags[2];
	assign saver = sensor_flags[3];
	assign sc_av = sensor_flags[4];
	assign awake = sensor_flags[5];
	assign ch_av = sensor_flags[6];
	assign chg   = sensor_flags[7];
	assign au_av = sensor_flags[8];
	assign au_on = sensor_flags[9];

	// thermal judgement, negative levels never reach a threshold
	assign lvl_known = (thermal_level != -4'sd1);
	assign lvl_emerg = lvl_known && (thermal_level >= $signed({1'b0, cfg.emerg_lvl}));
	assign lvl_press = lvl_known && (thermal_level >= $signed({1'b0, cfg.press_lvl}));

	always_comb begin
		if (!sensor_flags[0] || !sensor_flags[1]) begin
			th = TH_UNKNOWN;
		end else if (headroom >= cfg.emerg_hr || lvl_emerg) begin
			th = TH_EMERG;
		end else if (headroom >= cfg.enter_hr || lvl_press) begin
			th = TH_PRESSURE;
		end else if (headroom <= cfg.exit_hr) begin
			th = TH_RECOVER;
		end else begin
			th = TH_BAND;
		end
	end

	// time since the last thermal switch, saturating at zero
	assign diff    = {1'b0, now_time} - {1'b0, last_switch_q};
	assign elapsed = diff[TIME_BITS] ? '0 : diff[TIME_BITS-1:0];
	assign hold_done      = (elapsed >= TIME_BITS'(cfg.hold_time));
	assign debounce_short = (elapsed < TIME_BITS'(cfg.debounce));

	assign perf_now = (cur_prof_q == tppp_pkg::PROF_PERF) ||
	                  (cur_prof_q == tppp_pkg::PROF_LITE);

	// rule chain in priority order
	always_comb begin
		had_tel_d       = had_tel_q;
		prev_saver_d    = prev_saver_q;
		prev_awake_d    = prev_awake_q;
		prev_charging_d = prev_charging_q;
		last_switch_d   = last_switch_q;
		restored        = !had_tel_q;
		saver_cleared   = prev_saver_q && pw_av;
		wake_edge       = !prev_awake_q && awake;
		prof            = tppp_pkg::PROF_BAL;
		reason          = tppp_pkg::RSN_NONE;
		safety          = 1'b1;
		last_reason_d   = last_reason_q;
		if (shutdown_req) begin
			reason        = tppp_pkg::RSN_SHUTDOWN;
			last_reason_d = reason;
		end else if (health[1]) begin
			had_tel_d     = 1'b0;
			reason        = tppp_pkg::RSN_OFFLINE;
			last_reason_d = reason;
		end else begin
			had_tel_d = 1'b1;
			if (th == TH_EMERG) begin
				last_switch_d = now_time;
				reason        = tppp_pkg::RSN_EMERG;
				last_reason_d = reason;
			end else if (pw_av && saver) begin
				prev_saver_d  = 1'b1;
				prof          = tppp_pkg::PROF_SAVE;
				reason        = tppp_pkg::RSN_SAVER_ON;
				last_reason_d = reason;
			end else begin
				prev_saver_d = 1'b0;
				if (sc_av && !awake) begin
					prev_awake_d  = 1'b0;
					reason        = tppp_pkg::RSN_SCREEN_OFF;
					last_reason_d = reason;
				end else begin
					prev_awake_d = !sc_av || awake;
					safety       = 1'b0;
					// game session rules
					if (game) begin
						prof   = tppp_pkg::PROF_PERF;
						reason = restored ? tppp_pkg::RSN_RESTORED :
						         (perf_now ? tppp_pkg::RSN_NONE : tppp_pkg::RSN_GAME_START);
						if (force_lite) begin
							prof = tppp_pkg::PROF_LITE;
						end else if (th == TH_PRESSURE) begin
							prof   = tppp_pkg::PROF_LITE;
							reason = tppp_pkg::RSN_PRESSURE;
							safety = 1'b1;
						end else if (th == TH_UNKNOWN) begin
							prof = (sensor_flags[0] && cur_prof_q == tppp_pkg::PROF_LITE) ?
							       tppp_pkg::PROF_LITE : tppp_pkg::PROF_PERF;
						end else if (cur_prof_q == tppp_pkg::PROF_LITE) begin
							if (th == TH_RECOVER && hold_done) begin
								prof   = tppp_pkg::PROF_PERF;
								reason = tppp_pkg::RSN_RECOVER;
							end else begin
								prof = tppp_pkg::PROF_LITE;
							end
						end
						// debounce of thermal driven tier changes
						if ((reason == tppp_pkg::RSN_PRESSURE || reason == tppp_pkg::RSN_RECOVER)
						    && prof != cur_prof_q) begin
							if (debounce_short) begin
								prof   = cur_prof_q;
								reason = tppp_pkg::RSN_NONE;
								safety = 1'b0;
							end else begin
								last_switch_d = now_time;
							end
						end
					end else begin
						prof = tppp_pkg::PROF_BAL;
						if (saver_cleared) begin
							reason = tppp_pkg::RSN_SAVER_OFF;
						end else if (wake_edge) begin
							reason = tppp_pkg::RSN_SCREEN_ON;
						end else if (restored) begin
							reason = tppp_pkg::RSN_RESTORED;
						end else if (ch_av && chg != prev_charging_q) begin
							reason = tppp_pkg::RSN_CHARGING;
						end else begin
							reason = (cur_prof_q == tppp_pkg::PROF_BAL) ?
							         tppp_pkg::RSN_NONE : tppp_pkg::RSN_GAME_END;
						end
					end
					prev_charging_d = ch_av && chg;
					// stale telemetry veto on promotion
					if (health == tppp_pkg::HEALTH_STALE && prof > cur_prof_q) begin
						prof   = cur_prof_q;
						reason = tppp_pkg::RSN_STALE;
						safety = 1'b1;
					end
					// audio guard on non-safety changes
					if (!safety && au_av && au_on && perf_now && prof != cur_prof_q) begin
						prof   = cur_prof_q;
						reason = tppp_pkg::RSN_NONE;
					end
					if (reason != tppp_pkg::RSN_NONE) begin
						last_reason_d = reason;
					end
				end
			end
		end
		cur_prof_d = prof;
	end

	// result of the item in flight
	assign res.profile         = prof;
	assign res.reason_code     = reason;
	assign res.safety_flag     = safety;
	assign res.changed         = (prof != cur_prof_q);
	assign res.recorded_reason = last_reason_d;

	// state update on each decided item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_prof_q      <= tppp_pkg::PROF_BAL;
			last_reason_q   <= tppp_pkg::RSN_NONE;
			had_tel_q       <= 1'b0;
			prev_saver_q    <= 1'b0;
			prev_awake_q    <= 1'b1;
			prev_charging_q <= 1'b0;
			last_switch_q   <= '0;
		end else if (advance) begin
			cur_prof_q      <= cur_prof_d;
			last_reason_q   <= last_reason_d;
			had_tel_q       <= had_tel_d;
			prev_saver_q    <= prev_saver_d;
			prev_awake_q    <= prev_awake_d;
			prev_charging_q <= prev_charging_d;
			last_switch_q   <= last_switch_d;
		end
	end

endmodule

@@ rtl/thermal_power_profile_policy.sv @@
// top level of the thermal and power profile policy: handshake, stage registers, config
//
//  channel   direction  signals                         content
//  s_*       in         s_tvalid s_tready s_tdata       one telemetry sample per item
//  m_*       out        m_tvalid m_tready m_tdata       one profile decision per item
//  cfg_*     in         cfg_wr_en cfg_addr cfg_wdata    register writes, no read-back
//
//  one item per cycle sustained while m_tready stays high; a taken item passes through the
//  input register, then decision logic into the result register, where it is presented
//  the decision of an item updates the policy state as it moves into the result register,
//  so the next item to be decided sees it
//  m_tready low holds the result register and, once the input register is also full,
//  drops s_tready; arst_n resets state and config and clears both valid flags
module thermal_power_profile_policy #(
	parameter int TIME_BITS = tppp_pkg::TIME_BITS_DEF,
	localparam int IN_BITS  = tppp_pkg::IN_FIXED_W + TIME_BITS,
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_W    = ((tppp_pkg::RES_W + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// health[1:0] shutdown_req[2] sensor_flags[12:3] in_game[13] package_known[14]
	// force_lite[15] headroom[31:16] thermal_level[35:32] now_time[35+TIME_BITS:36]
	input  logic [IN_W-1:0]                  s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// profile[2:0] reason_code[7:3] safety_flag[8] changed[9] recorded_reason[14:10]
	output logic [OUT_W-1:0]                 m_tdata,
	input  logic                             cfg_wr_en,
	input  logic [tppp_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  logic [tppp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	tppp_pkg::cfg_t cfg;
	tppp_pkg::res_t res;
	tppp_pkg::res_t res_q;

	logic               valid_s1;
	logic [IN_BITS-1:0] item_s1;
	logic               m_valid_q;
	logic               out_free;
	logic               advance;
	logic               s_acc;

	// handshake
	assign out_free = !m_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign s_acc    = s_tvalid && s_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			item_s1 <= s_tdata[IN_BITS-1:0];
		end
	end

	tppp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tppp_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.cfg           (cfg),
		.health        (item_s1[1:0]),
		.shutdown_req  (item_s1[2]),
		.sensor_flags  (item_s1[12:3]),
		.in_game       (item_s1[13]),
		.package_known (item_s1[14]),
		.force_lite    (item_s1[15]),
		.headroom      (item_s1[31:16]),
		.thermal_level (item_s1[35:32]),
		.now_time      (item_s1[IN_BITS-1:tppp_pkg::IN_FIXED_W]),
		.res           (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_W'(res_q);

	// input side only stalls when both stages are full and the output is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_valid_q && !m_tready))
		else $error("input stalled without a held result");

	// every decided item shows up as a result
	a_advance_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_valid_q)
		else $error("decided item did not reach the result register");

	// profile stays within the defined tiers
	a_profile_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (res_q.profile <= tppp_pkg::PROF_PERF))
		else $error("profile out of range");

	// a non-none reason is always the one recorded
	a_reason_recorded: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && res_q.reason_code != tppp_pkg::RSN_NONE) |->
		(res_q.recorded_reason == res_q.reason_code))
		else $error("reason not recorded");

	// powersave is only ever chosen by the saver rule
	a_save_reason: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && res_q.changed && res_q.profile == tppp_pkg::PROF_SAVE) |->
		(res_q.reason_code == tppp_pkg::RSN_SAVER_ON))
		else $error("powersave without saver reason");

endmodule
